/* design/mcp_pkg.sv */
// ----------------------------------------------------------------------------
// mcp_pkg - shared types and constants for the multi-channel pipe table
// Operation and status codes, table sizes and the queue entry format.
// ----------------------------------------------------------------------------
package mcp_pkg;

	// table dimensions
	localparam int NUM_PIPES = 8;
	localparam int BUF_BYTES = 1024;
	localparam int MAX_REFS  = 15;

	// derived widths
	localparam int PIPE_W = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1;
	localparam int PTR_W  = $clog2(BUF_BYTES);
	localparam int CNT_W  = $clog2(BUF_BYTES + 1);
	localparam int REF_W  = $clog2(MAX_REFS + 1);
	localparam int MEM_D  = NUM_PIPES * BUF_BYTES;
	localparam int MEM_AW = $clog2(MEM_D);

	// raw kind codes on the input stream
	localparam logic [2:0] KIND_CREATE   = 3'd0;
	localparam logic [2:0] KIND_ADD_RD   = 3'd1;
	localparam logic [2:0] KIND_ADD_WR   = 3'd2;
	localparam logic [2:0] KIND_CLOSE_RD = 3'd3;
	localparam logic [2:0] KIND_CLOSE_WR = 3'd4;
	localparam logic [2:0] KIND_READ     = 3'd5;
	localparam logic [2:0] KIND_WRITE    = 3'd6;

	// decoded operation class
	typedef enum logic [2:0] {
		OP_CREATE,
		OP_ADD_RD,
		OP_ADD_WR,
		OP_CLOSE_RD,
		OP_CLOSE_WR,
		OP_READ,
		OP_WRITE,
		OP_BAD
	} op_kind_t;

	// result status codes
	typedef enum logic [2:0] {
		ST_OK,
		ST_BLOCK,
		ST_EOF,
		ST_BROKEN,
		ST_INVALID,
		ST_NONE_FREE,
		ST_REF_LIMIT
	} status_t;

	// one classified operation, as held in the queue
	typedef struct packed {
		op_kind_t   op;
		logic [2:0] pipe;
		logic [7:0] wbyte;
		logic       last;
	} mcp_op_t;

	// queue handshake towards the back end
	typedef struct packed {
		logic    valid;
		mcp_op_t entry;
	} mcp_q_out_t;

endpackage

/* design/multi_channel_pipe_fifo_top.sv */
// ----------------------------------------------------------------------------
// multi_channel_pipe_fifo_top - table of eight byte pipes
// Decode front end, two-entry operation queue and execution back end with
// per-pipe counters, a shared byte store and a result register.
//
//  port group   dir   tdata / tuser / tlast
//  s_*          in    pipe_index, write_byte / kind / last_of_call
//  m_*          out   read_byte, created_index, wake_waiters / status / last_out
//
// One operation a cycle while the output is not stalled; a result can be taken
// once its operation has passed the queue slot and then the result register,
// with the byte store read registered alongside it.
// The back end executes whenever the result register is empty or is being
// taken; the queue absorbs two operations while the output stalls.
// Reset clears all pipe counters at once; the byte store needs no clearing.
// ----------------------------------------------------------------------------
module multi_channel_pipe_fifo_top import mcp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // [2:0] pipe_index, [10:3] write_byte, rest zero
	input  logic        s_tlast,  // last_of_call
	input  logic [2:0]  s_tuser,  // [2:0] kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // [7:0] read_byte, [10:8] created_index,
	                              // [11] wake_waiters, rest zero
	output logic        m_tlast,  // last_out
	output logic [2:0]  m_tuser   // [2:0] status
);

	logic       q_full;
	logic       q_push;
	logic       q_pop;
	mcp_op_t    q_entry;
	mcp_q_out_t q_head;

	mcp_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_entry  (q_entry)
	);

	mcp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.full       (q_full),
		.pop        (q_pop),
		.head       (q_head)
	);

	mcp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (q_head),
		.pop      (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

/* design/mcp_front.sv */
// ----------------------------------------------------------------------------
// mcp_front - input side of the pipe table
// Takes input transactions, decodes the kind code into an operation class
// and pushes the result into the operation queue.
// ----------------------------------------------------------------------------
module mcp_front import mcp_pkg::*; (
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // [2:0] pipe_index, [10:3] write_byte, rest zero
	input  logic        s_tlast,  // last_of_call
	input  logic [2:0]  s_tuser,  // [2:0] kind
	input  logic        q_full,
	output logic        q_push,
	output mcp_op_t     q_entry
);

	op_kind_t op;

	// kind decode; the unused code becomes a bad operation
	always_comb begin
		case (s_tuser)
			KIND_CREATE:   op = OP_CREATE;
			KIND_ADD_RD:   op = OP_ADD_RD;
			KIND_ADD_WR:   op = OP_ADD_WR;
			KIND_CLOSE_RD: op = OP_CLOSE_RD;
			KIND_CLOSE_WR: op = OP_CLOSE_WR;
			KIND_READ:     op = OP_READ;
			KIND_WRITE:    op = OP_WRITE;
			default:       op = OP_BAD;
		endcase
	end

	// push whenever the queue has room
	assign s_tready      = !q_full;
	assign q_push        = s_tvalid && !q_full;
	assign q_entry.op    = op;
	assign q_entry.pipe  = s_tdata[2:0];
	assign q_entry.wbyte = s_tdata[10:3];
	assign q_entry.last  = s_tlast;

endmodule

/* design/mcp_queue.sv */
// ----------------------------------------------------------------------------
// mcp_queue - two-entry operation queue
// Decouples the decode side from the execution side so either can stall.
// ----------------------------------------------------------------------------
module mcp_queue import mcp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  mcp_op_t    push_entry,
	output logic       full,
	input  logic       pop,
	output mcp_q_out_t head
);

	mcp_op_t    slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full       = (count_q == 2'd2);
	assign head.valid = (count_q != 2'd0);
	assign head.entry = slot_q[rd_ptr_q];

	// pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_entry;
	end

endmodule

/* design/mcp_back.sv */
// ----------------------------------------------------------------------------
// mcp_back - execution side of the pipe table
// Pops one operation a cycle unless the output stalls, updates the per-pipe
// counters, reads or writes the byte store and holds the result in the output register.
// ----------------------------------------------------------------------------
module mcp_back import mcp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  mcp_q_out_t  head,
	output logic        pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // [7:0] read_byte, [10:8] created_index,
	                              // [11] wake_waiters, rest zero
	output logic        m_tlast,  // last_out
	output logic [2:0]  m_tuser   // [2:0] status
);

	// per-pipe control state
	logic             in_use_q [NUM_PIPES];
	logic [PTR_W-1:0] rd_ptr_q [NUM_PIPES];
	logic [PTR_W-1:0] wr_ptr_q [NUM_PIPES];
	logic [CNT_W-1:0] fill_q   [NUM_PIPES];
	logic [REF_W-1:0] rrefs_q  [NUM_PIPES];
	logic [REF_W-1:0] wrefs_q  [NUM_PIPES];

	// byte store
	logic [7:0] mem [MEM_D];
	logic [7:0] rd_data_q;

	// output register
	logic       valid_s1;
	status_t    status_s1;
	logic       use_rd_s1;
	logic [2:0] made_s1;
	logic       wake_s1;
	logic       last_s1;

	// execution signals
	logic             exec;
	mcp_op_t          e;
	logic [PIPE_W-1:0] pidx;
	logic             live;
	logic             free_found;
	logic [PIPE_W-1:0] free_idx;
	logic [PTR_W-1:0] rp_cur, wp_cur, rp_nxt, wp_nxt;
	logic [CNT_W-1:0] fill_cur;
	logic [REF_W-1:0] rr_cur, wr_cur, rr_nxt, wr_nxt;
	status_t          status;
	logic             wake, do_rd, do_wr, do_create, do_ctrl, free_it;
	logic [MEM_AW-1:0] mem_addr;

	assign e    = head.entry;
	assign exec = head.valid && (!valid_s1 || m_tready);
	assign pop  = exec;
	assign pidx = e.pipe[PIPE_W-1:0];
	assign live = (32'(e.pipe) < NUM_PIPES) && in_use_q[pidx];

	assign rp_cur   = rd_ptr_q[pidx];
	assign wp_cur   = wr_ptr_q[pidx];
	assign fill_cur = fill_q[pidx];
	assign rr_cur   = rrefs_q[pidx];
	assign wr_cur   = wrefs_q[pidx];

	// ring pointer increments
	assign rp_nxt = (32'(rp_cur) == BUF_BYTES - 1) ? '0 : rp_cur + PTR_W'(1);
	assign wp_nxt = (32'(wp_cur) == BUF_BYTES - 1) ? '0 : wp_cur + PTR_W'(1);

	// lowest free pipe
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = NUM_PIPES - 1; i >= 0; i--) begin
			if (!in_use_q[i]) begin
				free_found = 1'b1;
				free_idx   = PIPE_W'(i);
			end
		end
	end

	// operation decision
	always_comb begin
		status    = ST_INVALID;
		wake      = 1'b0;
		do_rd     = 1'b0;
		do_wr     = 1'b0;
		do_create = 1'b0;
		do_ctrl   = 1'b0;
		free_it   = 1'b0;
		rr_nxt    = rr_cur;
		wr_nxt    = wr_cur;
		if (e.op == OP_CREATE) begin
			status    = free_found ? ST_OK : ST_NONE_FREE;
			do_create = free_found;
		end else if (live) begin
			case (e.op)
				OP_ADD_RD: begin
					if (rr_cur >= REF_W'(MAX_REFS)) status = ST_REF_LIMIT;
					else begin
						status  = ST_OK;
						rr_nxt  = rr_cur + REF_W'(1);
						do_ctrl = 1'b1;
					end
				end
				OP_ADD_WR: begin
					if (wr_cur >= REF_W'(MAX_REFS)) status = ST_REF_LIMIT;
					else begin
						status  = ST_OK;
						wr_nxt  = wr_cur + REF_W'(1);
						do_ctrl = 1'b1;
					end
				end
				OP_CLOSE_RD, OP_CLOSE_WR: begin
					if (e.op == OP_CLOSE_RD && rr_cur != '0) rr_nxt = rr_cur - REF_W'(1);
					if (e.op == OP_CLOSE_WR && wr_cur != '0) wr_nxt = wr_cur - REF_W'(1);
					free_it = (rr_nxt == '0) && (wr_nxt == '0);
					status  = ST_OK;
					wake    = 1'b1;
					do_ctrl = 1'b1;
				end
				OP_READ: begin
					if (fill_cur != '0) begin
						status = ST_OK;
						wake   = 1'b1;
						do_rd  = 1'b1;
					end else if (wr_cur == '0) status = ST_EOF;
					else status = ST_BLOCK;
				end
				OP_WRITE: begin
					if (rr_cur == '0) status = ST_BROKEN;
					else if (fill_cur < CNT_W'(BUF_BYTES)) begin
						status = ST_OK;
						wake   = 1'b1;
						do_wr  = 1'b1;
					end else status = ST_BLOCK;
				end
				default: status = ST_INVALID;
			endcase
		end
	end

	assign mem_addr = MEM_AW'(32'(pidx) * BUF_BYTES + 32'(do_rd ? rp_cur : wp_cur));

	// control state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PIPES; i++) begin
				in_use_q[i] <= 1'b0;
				rd_ptr_q[i] <= '0;
				wr_ptr_q[i] <= '0;
				fill_q[i]   <= '0;
				rrefs_q[i]  <= '0;
				wrefs_q[i]  <= '0;
			end
		end else if (exec) begin
			if (do_create) begin
				in_use_q[free_idx] <= 1'b1;
				rd_ptr_q[free_idx] <= '0;
				wr_ptr_q[free_idx] <= '0;
				fill_q[free_idx]   <= '0;
				rrefs_q[free_idx]  <= REF_W'(1);
				wrefs_q[free_idx]  <= REF_W'(1);
			end
			if (do_ctrl) begin
				rrefs_q[pidx] <= rr_nxt;
				wrefs_q[pidx] <= wr_nxt;
				if (free_it) in_use_q[pidx] <= 1'b0;
			end
			if (do_rd) begin
				rd_ptr_q[pidx] <= rp_nxt;
				fill_q[pidx]   <= fill_cur - CNT_W'(1);
			end
			if (do_wr) begin
				wr_ptr_q[pidx] <= wp_nxt;
				fill_q[pidx]   <= fill_cur + CNT_W'(1);
			end
		end
	end

	// byte store, registered read
	always_ff @(posedge clk) begin
		if (exec && do_wr) mem[mem_addr] <= e.wbyte;
		if (exec && do_rd) rd_data_q <= mem[mem_addr];
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else if (exec) valid_s1 <= 1'b1;
		else if (m_tready) valid_s1 <= 1'b0;
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (exec) begin
			status_s1 <= status;
			use_rd_s1 <= do_rd;
			made_s1   <= do_create ? 3'(free_idx) : 3'd0;
			wake_s1   <= wake;
			last_s1   <= e.last;
		end
	end

	assign m_tvalid = valid_s1;
	assign m_tuser  = status_s1;
	assign m_tlast  = last_s1;
	assign m_tdata  = {4'd0, wake_s1, made_s1, use_rd_s1 ? rd_data_q : 8'd0};

`ifndef SYNTHESIS
	a_refs_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		exec && live |-> rr_cur <= REF_W'(MAX_REFS) && wr_cur <= REF_W'(MAX_REFS))
		else $error("reference count above limit");
	a_fill_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		exec && live |-> fill_cur <= CNT_W'(BUF_BYTES))
		else $error("fill count above buffer size");
	a_create_marks: assert property (@(posedge clk) disable iff (!arst_n)
		exec && do_create |=> in_use_q[$past(free_idx)])
		else $error("created pipe not marked in use");
	a_rd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !m_tready |=> $stable(rd_data_q))
		else $error("read data changed under a stalled result");
`endif

endmodule
